[rtl/ltm_pkg.sv]
// Shared constants and word types for the luminance tone mapper.
package ltm_pkg;

    localparam int RADIANCE_FRAC_BITS = 16;
    localparam int WEIGHT_FRAC_BITS   = 14;
    localparam int SCALE_FRAC_BITS    = 16;

    localparam int RAD_W    = 32;
    localparam int WEIGHT_W = 16;
    localparam int LEVEL_W  = 8;
    localparam int NUM_CHAN = 3;

    localparam int PEAK_BITS = LEVEL_W;
    localparam logic [PEAK_BITS-1:0] PEAK_LEVEL = PEAK_BITS'(255);

    // weight * radiance, luminance sum, 255 * luminance
    localparam int PROD_W   = WEIGHT_W + RAD_W;
    localparam int LUM_W    = PROD_W + 2;
    localparam int SCALED_W = LUM_W + PEAK_BITS;
    localparam int DEN_W    = LUM_W + 1;

    // peak level with SCALE_FRAC_BITS fraction bits, below 255 * 2^SCALE_FRAC_BITS
    localparam int PEAK_W  = PEAK_BITS + SCALE_FRAC_BITS;
    localparam int CHPROD_W = PEAK_W + RAD_W;

    localparam logic [DEN_W-1:0] LUM_ONE =
        DEN_W'(1) << (RADIANCE_FRAC_BITS + WEIGHT_FRAC_BITS);

    localparam int S_TDATA_W = NUM_CHAN * RAD_W;
    localparam int M_TDATA_W = NUM_CHAN * LEVEL_W;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_RED_WEIGHT   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_GREEN_WEIGHT = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_BLUE_WEIGHT  = CFG_INDEX_W'(2);

    localparam logic [WEIGHT_W-1:0] RED_WEIGHT_RESET   = WEIGHT_W'(3483);
    localparam logic [WEIGHT_W-1:0] GREEN_WEIGHT_RESET = WEIGHT_W'(11718);
    localparam logic [WEIGHT_W-1:0] BLUE_WEIGHT_RESET  = WEIGHT_W'(1183);

    typedef struct packed {
        logic [RAD_W-1:0] blue;
        logic [RAD_W-1:0] green;
        logic [RAD_W-1:0] red;
    } pixel_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] blue;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] red;
    } level_t;

    // data that rides along with the arithmetic
    typedef struct packed {
        pixel_t           pix;
        logic [RAD_W-1:0] peak;   // brightest channel
        logic             black;  // all channels zero
    } side_t;

    typedef struct packed {
        side_t                side;
        logic [LUM_W-1:0]     rem;  // (255 * L) >> 8
        logic [PEAK_BITS-1:0] low;  // (255 * L) low bits
        logic [DEN_W-1:0]     den;  // L + one
    } div_in_t;

    typedef struct packed {
        side_t             side;
        logic [PEAK_W-1:0] peak_level;
    } scale_in_t;

endpackage

[rtl/ltm_lum.sv]
// Luminance stages: weight products, sum, and divider operand setup.
module ltm_lum (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  ltm_pkg::pixel_t               pix,
    input  logic [ltm_pkg::WEIGHT_W-1:0]  red_weight,
    input  logic [ltm_pkg::WEIGHT_W-1:0]  green_weight,
    input  logic [ltm_pkg::WEIGHT_W-1:0]  blue_weight,
    output logic                          out_valid,
    output ltm_pkg::div_in_t              out_word
);
    import ltm_pkg::*;

    logic [2:0]          valid_reg;
    logic [PROD_W-1:0]   prod_red_reg;
    logic [PROD_W-1:0]   prod_green_reg;
    logic [PROD_W-1:0]   prod_blue_reg;
    side_t               side1_reg;
    side_t               side2_reg;
    logic [LUM_W-1:0]    lum_reg;
    div_in_t             word_reg;

    side_t               side1_next;
    logic [SCALED_W-1:0] scaled;

    // brightest channel, ties to red then green
    always_comb
    begin
        side1_next.pix   = pix;
        if (pix.red >= pix.green && pix.red >= pix.blue)
            side1_next.peak = pix.red;
        else if (pix.green >= pix.blue)
            side1_next.peak = pix.green;
        else
            side1_next.peak = pix.blue;
        side1_next.black = (side1_next.peak == '0);
    end

    assign scaled = SCALED_W'(lum_reg) * SCALED_W'(PEAK_LEVEL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_red_reg   <= PROD_W'(red_weight) * PROD_W'(pix.red);
            prod_green_reg <= PROD_W'(green_weight) * PROD_W'(pix.green);
            prod_blue_reg  <= PROD_W'(blue_weight) * PROD_W'(pix.blue);
            side1_reg      <= side1_next;

            lum_reg   <= LUM_W'(prod_red_reg) + LUM_W'(prod_green_reg)
                       + LUM_W'(prod_blue_reg);
            side2_reg <= side1_reg;

            word_reg.side <= side2_reg;
            word_reg.rem  <= scaled[SCALED_W-1:PEAK_BITS];
            word_reg.low  <= scaled[PEAK_BITS-1:0];
            word_reg.den  <= DEN_W'(lum_reg) + LUM_ONE;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_word  = word_reg;

endmodule

[rtl/ltm_peak_div.sv]
// Pipelined restoring divider for the peak level 255*L*2^16 / (L + one).
module ltm_peak_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  ltm_pkg::div_in_t   in_word,
    output logic               out_valid,
    output ltm_pkg::scale_in_t out_word
);
    import ltm_pkg::*;

    logic [PEAK_W-1:0] valid_reg;
    logic [DEN_W-1:0]  rem_reg  [PEAK_W];
    logic [PEAK_W-1:0] num_reg  [PEAK_W];
    logic [PEAK_W-1:0] quo_reg  [PEAK_W];
    logic [DEN_W-1:0]  den_reg  [PEAK_W];
    side_t             side_reg [PEAK_W];

    logic [DEN_W-1:0]  rem_in   [PEAK_W];
    logic [PEAK_W-1:0] num_in   [PEAK_W];
    logic [PEAK_W-1:0] quo_in   [PEAK_W];
    logic [DEN_W-1:0]  den_in   [PEAK_W];
    side_t             side_in  [PEAK_W];

    logic [DEN_W-1:0]  rem_next [PEAK_W];
    logic [PEAK_W-1:0] quo_next [PEAK_W];

    always_comb
    begin
        rem_in[0]  = in_word.rem;
        num_in[0]  = {in_word.low, {SCALE_FRAC_BITS{1'b0}}};
        quo_in[0]  = '0;
        den_in[0]  = in_word.den;
        side_in[0] = in_word.side;
        for (int k = 1; k < PEAK_W; k++)
        begin
            rem_in[k]  = rem_reg[k-1];
            num_in[k]  = num_reg[k-1];
            quo_in[k]  = quo_reg[k-1];
            den_in[k]  = den_reg[k-1];
            side_in[k] = side_reg[k-1];
        end
    end

    // one quotient bit per stage; the leading remainder is already below den
    always_comb
    begin
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;
        for (int k = 0; k < PEAK_W; k++)
        begin
            trial       = {rem_in[k], num_in[k][PEAK_W-1]};
            diff        = trial - {1'b0, den_in[k]};
            ge          = (trial >= {1'b0, den_in[k]});
            rem_next[k] = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next[k] = {quo_in[k][PEAK_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[PEAK_W-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < PEAK_W; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                num_reg[k]  <= num_in[k] << 1;
                quo_reg[k]  <= quo_next[k];
                den_reg[k]  <= den_in[k];
                side_reg[k] <= side_in[k];
            end
        end
    end

    assign out_valid           = valid_reg[PEAK_W-1];
    assign out_word.side       = side_reg[PEAK_W-1];
    assign out_word.peak_level = quo_reg[PEAK_W-1];

endmodule

[rtl/ltm_scale.sv]
// Channel scaling: level * channel / peak channel, one quotient bit per stage.
module ltm_scale (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  ltm_pkg::scale_in_t in_word,
    output logic               out_valid,
    output ltm_pkg::level_t    out_word
);
    import ltm_pkg::*;

    logic                           prod_valid_reg;
    logic [CHPROD_W-1:0]            prod_reg [NUM_CHAN];
    side_t                          prod_side_reg;

    logic [LEVEL_W-1:0]             valid_reg;
    logic [RAD_W-1:0]               rem_reg  [LEVEL_W][NUM_CHAN];
    logic [LEVEL_W-1:0]             num_reg  [LEVEL_W][NUM_CHAN];
    logic [LEVEL_W-1:0]             quo_reg  [LEVEL_W][NUM_CHAN];
    side_t                          side_reg [LEVEL_W];

    logic [RAD_W-1:0]               chan     [NUM_CHAN];
    logic [RAD_W-1:0]               rem_in   [LEVEL_W][NUM_CHAN];
    logic [LEVEL_W-1:0]             num_in   [LEVEL_W][NUM_CHAN];
    logic [LEVEL_W-1:0]             quo_in   [LEVEL_W][NUM_CHAN];
    side_t                          side_in  [LEVEL_W];
    logic [RAD_W-1:0]               rem_next [LEVEL_W][NUM_CHAN];
    logic [LEVEL_W-1:0]             quo_next [LEVEL_W][NUM_CHAN];

    assign chan[0] = in_word.side.pix.red;
    assign chan[1] = in_word.side.pix.green;
    assign chan[2] = in_word.side.pix.blue;

    // floor(S*c / (peak * 2^16)) == floor((S*c >> 16) / peak); top bits start below peak
    always_comb
    begin
        side_in[0] = prod_side_reg;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            rem_in[0][c] = prod_reg[c][CHPROD_W-1:PEAK_W];
            num_in[0][c] = prod_reg[c][PEAK_W-1:SCALE_FRAC_BITS];
            quo_in[0][c] = '0;
        end
        for (int k = 1; k < LEVEL_W; k++)
        begin
            side_in[k] = side_reg[k-1];
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                rem_in[k][c] = rem_reg[k-1][c];
                num_in[k][c] = num_reg[k-1][c];
                quo_in[k][c] = quo_reg[k-1][c];
            end
        end
    end

    always_comb
    begin
        logic [RAD_W:0] trial;
        logic [RAD_W:0] diff;
        logic           ge;
        for (int k = 0; k < LEVEL_W; k++)
        begin
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                trial          = {rem_in[k][c], num_in[k][c][LEVEL_W-1]};
                diff           = trial - {1'b0, side_in[k].peak};
                ge             = (trial >= {1'b0, side_in[k].peak});
                rem_next[k][c] = ge ? diff[RAD_W-1:0] : trial[RAD_W-1:0];
                quo_next[k][c] = {quo_in[k][c][LEVEL_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            valid_reg      <= '0;
        end
        else if (en)
        begin
            prod_valid_reg <= in_valid;
            valid_reg      <= {valid_reg[LEVEL_W-2:0], prod_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < NUM_CHAN; c++)
                prod_reg[c] <= CHPROD_W'(in_word.peak_level) * CHPROD_W'(chan[c]);
            prod_side_reg <= in_word.side;
            for (int k = 0; k < LEVEL_W; k++)
            begin
                side_reg[k] <= side_in[k];
                for (int c = 0; c < NUM_CHAN; c++)
                begin
                    rem_reg[k][c] <= rem_next[k][c];
                    num_reg[k][c] <= num_in[k][c] << 1;
                    quo_reg[k][c] <= quo_next[k][c];
                end
            end
        end
    end

    // a black pixel has a zero divisor; force zero
    assign out_valid      = valid_reg[LEVEL_W-1];
    assign out_word.red   = side_reg[LEVEL_W-1].black ? '0 : quo_reg[LEVEL_W-1][0];
    assign out_word.green = side_reg[LEVEL_W-1].black ? '0 : quo_reg[LEVEL_W-1][1];
    assign out_word.blue  = side_reg[LEVEL_W-1].black ? '0 : quo_reg[LEVEL_W-1][2];

endmodule

[rtl/ltm_out_slice.sv]
// Output register with skid entry; the pipeline enable comes from a flop.
module ltm_out_slice (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  ltm_pkg::level_t in_word,
    output logic            en,
    output logic            out_valid,
    output ltm_pkg::level_t out_word,
    input  logic            out_ready
);
    import ltm_pkg::*;

    logic   out_valid_reg;
    logic   skid_valid_reg;
    level_t out_word_reg;
    level_t skid_word_reg;
    logic   push;
    logic   pop;

    assign en   = !skid_valid_reg;
    assign push = in_valid && en;
    assign pop  = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_word_reg <= skid_word_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_word_reg <= in_word;
            else
                out_word_reg <= in_word;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

[rtl/luminance_tone_map_rgb.sv]
// Top level of the Reinhard-style RGB tone mapper.
//
//  channel  | direction | word
//  ---------+-----------+----------------------------------------------
//  s_t*     | in        | one HDR pixel: red, green, blue radiance
//  m_t*     | out       | one display pixel: red, green, blue level
//  cfg_*    | in        | luminance weight writes, no read-back
//
// One pixel per clock while no m_tready stall holds the pipe. 36 pipeline
// stages (3 luminance, 24 peak divider steps, 1 channel multiply, 8 channel
// divider steps) then the output register.
// Reset clears valid bits and restores the default weights.
// A stall on m_tready fills the skid entry, then freezes the whole pipe.
module luminance_tone_map_rgb (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // red_radiance, green_radiance, blue_radiance
    input  logic [ltm_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // red_level, green_level, blue_level
    output logic [ltm_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              cfg_write,
    input  logic [ltm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ltm_pkg::WEIGHT_W-1:0]      cfg_data
);
    import ltm_pkg::*;

    logic [WEIGHT_W-1:0] red_weight_reg;
    logic [WEIGHT_W-1:0] green_weight_reg;
    logic [WEIGHT_W-1:0] blue_weight_reg;

    logic      en;
    pixel_t    pix;
    logic      lum_valid;
    div_in_t   lum_word;
    logic      peak_valid;
    scale_in_t peak_word;
    logic      scale_valid;
    level_t    scale_word;
    level_t    result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_weight_reg   <= RED_WEIGHT_RESET;
            green_weight_reg <= GREEN_WEIGHT_RESET;
            blue_weight_reg  <= BLUE_WEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_RED_WEIGHT:   red_weight_reg   <= cfg_data;
                REG_GREEN_WEIGHT: green_weight_reg <= cfg_data;
                REG_BLUE_WEIGHT:  blue_weight_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign pix.red   = s_tdata[RAD_W-1:0];
    assign pix.green = s_tdata[2*RAD_W-1:RAD_W];
    assign pix.blue  = s_tdata[3*RAD_W-1:2*RAD_W];

    assign s_tready = en;

    ltm_lum u_lum (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (s_tvalid),
        .pix          (pix),
        .red_weight   (red_weight_reg),
        .green_weight (green_weight_reg),
        .blue_weight  (blue_weight_reg),
        .out_valid    (lum_valid),
        .out_word     (lum_word)
    );

    ltm_peak_div u_peak_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (lum_valid),
        .in_word   (lum_word),
        .out_valid (peak_valid),
        .out_word  (peak_word)
    );

    ltm_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (peak_valid),
        .in_word   (peak_word),
        .out_valid (scale_valid),
        .out_word  (scale_word)
    );

    ltm_out_slice u_out_slice (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (scale_valid),
        .in_word   (scale_word),
        .en        (en),
        .out_valid (m_tvalid),
        .out_word  (result),
        .out_ready (m_tready)
    );

    assign m_tdata = {result.blue, result.green, result.red};

endmodule

[test/luminance_tone_map_rgb_test.sv]
// Self-checking stream testbench for the luminance_tone_map_rgb tone mapper.
`timescale 1ns / 100ps

module luminance_tone_map_rgb_test;

    import ltm_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = CFG_INDEX_W'(3);
    localparam int PIPE_LATENCY = 37;
    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 150;
    localparam logic [RAD_W-1:0] RAD_MAX = '1;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    // red_radiance, green_radiance, blue_radiance
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    // red_level, green_level, blue_level
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [WEIGHT_W-1:0]    cfg_data;

    // testbench copy of the luminance weights
    logic [WEIGHT_W-1:0] red_w;
    logic [WEIGHT_W-1:0] green_w;
    logic [WEIGHT_W-1:0] blue_w;

    pixel_t radiance_queue[$];
    level_t levels_expected[$];

    logic in_fire;
    logic calm;
    int   send_gap;
    int   stall_left;
    int   hold_cycles;
    int   idle_cycles;
    int   mismatch_count;

    luminance_tone_map_rgb uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // floor(peak * c / brightest) >> frac bits, clipped to the display range
    function automatic logic [LEVEL_W-1:0] scale_channel(input logic [127:0] peak,
                                                        input logic [RAD_W-1:0] chan,
                                                        input logic [RAD_W-1:0] brightest);
        logic [127:0] v;
        v = ((peak * chan) / brightest) >> SCALE_FRAC_BITS;
        if (v > 255)
            v = 255;
        return v[LEVEL_W-1:0];
    endfunction

    function automatic level_t tone_map(input pixel_t px);
        logic [127:0] luma;
        logic [127:0] peak;
        logic [RAD_W-1:0] brightest;
        level_t lv;
        lv = '0;
        luma = 128'(red_w) * px.red + 128'(green_w) * px.green + 128'(blue_w) * px.blue;
        brightest = px.red;
        if (px.green > brightest)
            brightest = px.green;
        if (px.blue > brightest)
            brightest = px.blue;
        if (brightest != 0)
        begin
            peak = ((luma * 255) << SCALE_FRAC_BITS)
                   / (luma + (128'(1) << (RADIANCE_FRAC_BITS + WEIGHT_FRAC_BITS)));
            lv.red   = scale_channel(peak, px.red, brightest);
            lv.green = scale_channel(peak, px.green, brightest);
            lv.blue  = scale_channel(peak, px.blue, brightest);
        end
        return lv;
    endfunction

    // spread magnitudes so luminance lands on both sides of 1.0
    function automatic pixel_t random_pixel();
        pixel_t px;
        int base;
        case ($urandom_range(0, 3))
            0:
            begin
                px.red   = $urandom;
                px.green = $urandom;
                px.blue  = $urandom;
            end
            1:
            begin
                base = $urandom_range(0, 28);
                px.red   = $urandom >> (base + $urandom_range(0, 3));
                px.green = $urandom >> (base + $urandom_range(0, 3));
                px.blue  = $urandom >> (base + $urandom_range(0, 3));
            end
            2:
            begin
                px.red   = $urandom_range(0, 32'h3FFFF);
                px.green = $urandom_range(0, 32'h3FFFF);
                px.blue  = $urandom_range(0, 32'h3FFFF);
            end
            default:
            begin
                px.red   = ($urandom_range(0, 2) == 0) ? RAD_MAX
                                                       : $urandom >> $urandom_range(0, 31);
                px.green = ($urandom_range(0, 2) == 0) ? '0
                                                       : $urandom >> $urandom_range(0, 31);
                px.blue  = ($urandom_range(0, 2) == 0) ? px.red
                                                       : $urandom >> $urandom_range(0, 31);
            end
        endcase
        return px;
    endfunction

    task automatic queue_pixel(input logic [RAD_W-1:0] r, input logic [RAD_W-1:0] g,
                               input logic [RAD_W-1:0] b);
        pixel_t px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        radiance_queue.push_back(px);
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            radiance_queue.push_back(random_pixel());
    endtask

    // sender stays quiet until every pixel is through and every level is back
    task automatic drain();
        while (radiance_queue.size() != 0 || s_tvalid)
            @(posedge clk);
        while (levels_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_weight(input logic [CFG_INDEX_W-1:0] index,
                                input logic [WEIGHT_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        case (index)
            REG_RED_WEIGHT:   red_w   = value;
            REG_GREEN_WEIGHT: green_w = value;
            REG_BLUE_WEIGHT:  blue_w  = value;
            default:          ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // sender
    always @(negedge clk)
    begin
        if (rst_n && (in_fire || !s_tvalid))
        begin
            if (in_fire && !calm && $urandom_range(0, 4) == 0)
                send_gap = $urandom_range(1, 3);
            if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (radiance_queue.size() != 0)
            begin
                s_tdata  <= radiance_queue.pop_front();
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles = hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // monitor, scoreboard and watchdog
    always @(posedge clk)
    begin
        level_t want;
        level_t got;
        in_fire <= s_tvalid && s_tready;
        if (rst_n)
        begin
            idle_cycles = idle_cycles + 1;
            if (s_tvalid && s_tready)
            begin
                levels_expected.push_back(tone_map(pixel_t'(s_tdata)));
                idle_cycles = 0;
            end
            if (m_tvalid && m_tready)
            begin
                idle_cycles = 0;
                got = level_t'(m_tdata);
                if (levels_expected.size() == 0)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("unexpected word: r %0d g %0d b %0d",
                                 got.red, got.green, got.blue);
                end
                else
                begin
                    want = levels_expected.pop_front();
                    if (got.red != want.red || got.green != want.green
                        || got.blue != want.blue)
                    begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10)
                            $display({"level mismatch: expected r %0d g %0d b %0d,",
                                      " got r %0d g %0d b %0d"},
                                     want.red, want.green, want.blue,
                                     got.red, got.green, got.blue);
                    end
                end
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = REG_RED_WEIGHT;
        cfg_data       = '0;
        in_fire        = 1'b0;
        calm           = 1'b0;
        send_gap       = 0;
        stall_left     = 0;
        hold_cycles    = 0;
        idle_cycles    = 0;
        mismatch_count = 0;
        red_w          = RED_WEIGHT_RESET;
        green_w        = GREEN_WEIGHT_RESET;
        blue_w         = BLUE_WEIGHT_RESET;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default weights: corners, ties, bit patterns
        queue_pixel(0, 0, 0);
        queue_pixel(RAD_MAX, RAD_MAX, RAD_MAX);
        queue_pixel(RAD_MAX, 0, 0);
        queue_pixel(0, RAD_MAX, 0);
        queue_pixel(0, 0, RAD_MAX);
        queue_pixel(1, 0, 0);
        queue_pixel(0, 0, 1);
        queue_pixel(32'h10000, 32'h10000, 32'h10000);
        queue_pixel(32'h10000, 32'h10000, 32'h8000);
        queue_pixel(5, 9, 9);
        queue_pixel(32'h30000, 1, 32'h30000);
        queue_pixel(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA);
        queue_pixel(32'h55555555, 32'hAAAAAAAA, 32'h55555555);
        queue_pixel(RAD_MAX, 1, 32'h80000000);
        queue_pixel(32'h8000, 32'h4000, 32'h2000);
        queue_pixel(32'hFFFF, 32'hFFFE, 1);
        queue_random(150);
        drain();

        // zero weights: luminance vanishes
        write_weight(REG_RED_WEIGHT, 0);
        write_weight(REG_GREEN_WEIGHT, 0);
        write_weight(REG_BLUE_WEIGHT, 0);
        @(posedge clk);
        queue_pixel(RAD_MAX, RAD_MAX, RAD_MAX);
        queue_pixel(1, 2, 3);
        queue_random(50);
        drain();

        // full-scale weights, with a long output hold to back up the pipe
        write_weight(REG_RED_WEIGHT, 16'hFFFF);
        write_weight(REG_GREEN_WEIGHT, 16'hFFFF);
        write_weight(REG_BLUE_WEIGHT, 16'hFFFF);
        @(posedge clk);
        queue_pixel(RAD_MAX, RAD_MAX, RAD_MAX);
        queue_pixel(1, 1, 1);
        queue_random(150);
        hold_cycles = LONG_HOLD;
        drain();

        // unused index leaves the weights alone, but all three are rewritten before pixels flow
        write_weight(REG_UNUSED, 16'h1234);
        write_weight(REG_RED_WEIGHT, WEIGHT_W'($urandom_range(0, 65535)));
        write_weight(REG_GREEN_WEIGHT, WEIGHT_W'($urandom_range(0, 65535)));
        write_weight(REG_BLUE_WEIGHT, WEIGHT_W'($urandom_range(0, 65535)));
        @(posedge clk);
        queue_random(150);
        drain();

        write_weight(REG_RED_WEIGHT, 0);
        write_weight(REG_GREEN_WEIGHT, 16'hFFFF);
        write_weight(REG_BLUE_WEIGHT, WEIGHT_W'($urandom_range(0, 65535)));
        @(posedge clk);
        queue_random(100);
        drain();

        // last stretch at full rate
        write_weight(REG_RED_WEIGHT, RED_WEIGHT_RESET);
        write_weight(REG_GREEN_WEIGHT, WEIGHT_W'($urandom_range(0, 65535)));
        write_weight(REG_BLUE_WEIGHT, BLUE_WEIGHT_RESET);
        @(posedge clk);
        calm = 1'b1;
        queue_random(100);
        drain();
        repeat (PIPE_LATENCY + 3) @(posedge clk);

        if (mismatch_count == 0 && levels_expected.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[luminance_tone_map_rgb.f]
rtl/ltm_pkg.sv
rtl/ltm_lum.sv
rtl/ltm_peak_div.sv
rtl/ltm_scale.sv
rtl/ltm_out_slice.sv
rtl/luminance_tone_map_rgb.sv
test/luminance_tone_map_rgb_test.sv
